// File: src/assert_macros.svh
// Assertion helpers shared by the AES-CTR RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AESCTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AESCTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/aesctr_pkg.sv
// Types, constants and round functions for the AES-128 CTR block.
// No dependencies.
package aesctr_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned RK_DEPTH   = 11;
    localparam int unsigned RK_AW      = 4;

    typedef enum logic [2:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3,
        REG_CTR_W    = 3'd4
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_ciph_state;

    typedef struct packed {
        logic              we;
        logic [RK_AW-1:0]  addr;
        logic [127:0]      data;
    } t_rk_wr;

    typedef struct packed {
        logic          start;
        logic [127:0]  ctr;
        logic [127:0]  data;
        logic [4:0]    nbytes;
    } t_ciph_req;

    typedef struct packed {
        logic idle;
    } t_ciph_stat;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [RK_AW-1:0] k);
        logic [7:0] r;
        case (k)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block sits at bits [127-8i -: 8]
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i+4*c] = b[i + 4*((c+i) & 3)];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                b[4*c]   = t[4*c]   ^ all ^ dbl(t[4*c]   ^ t[4*c+1]);
                b[4*c+1] = t[4*c+1] ^ all ^ dbl(t[4*c+1] ^ t[4*c+2]);
                b[4*c+2] = t[4*c+2] ^ all ^ dbl(t[4*c+2] ^ t[4*c+3]);
                b[4*c+3] = t[4*c+3] ^ all ^ dbl(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                b[i] = t[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = b[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // big-endian increment of the trailing cw bytes, wrapping within them
    function automatic logic [127:0] ctr_inc(input logic [127:0] c, input logic [4:0] cw);
        logic [4:0]   n;
        logic         carry;
        logic [127:0] r;
        n = (cw == 5'd0 || cw > 5'd16) ? 5'd4 : cw;
        carry = 1'b1;
        r = c;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < n && carry) begin
                r[8*i +: 8] = c[8*i +: 8] + 8'd1;
                carry = (r[8*i +: 8] == 8'd0);
            end
        end
        return r;
    endfunction

endpackage

// File: src/aesctr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aesctr_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/aesctr_keyexp.sv
// Key expansion sequencer: writes one round key per cycle into the key RAM.
// Depends on aesctr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module aesctr_keyexp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [127:0]          i_key,
    output aesctr_pkg::t_rk_wr    o_wr,
    output logic                  o_busy
);
    logic                          r_busy;
    logic                          n_busy;
    logic [aesctr_pkg::RK_AW-1:0]  r_idx;
    logic [aesctr_pkg::RK_AW-1:0]  n_idx;
    logic [127:0]                  r_key;
    logic [127:0]                  n_key;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_key  = r_key;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_key  = i_key;
        end else if (r_busy) begin
            n_key = aesctr_pkg::next_round_key(r_key, aesctr_pkg::rcon(r_idx + 1'b1));
            n_idx = r_idx + 1'b1;
            if (r_idx == aesctr_pkg::RK_AW'(aesctr_pkg::NUM_ROUNDS)) begin
                n_busy = 1'b0;
            end
        end
    end

    // reset expands the all-zero key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_key  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_key  <= n_key;
        end
    end

    assign o_wr.we   = r_busy;
    assign o_wr.addr = r_idx;
    assign o_wr.data = r_key;
    assign o_busy    = r_busy;

    `AESCTR_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_busy, r_idx <= aesctr_pkg::RK_AW'(aesctr_pkg::NUM_ROUNDS))
    `AESCTR_ASSERT_NXT(a_done, i_clk, i_rst_n, r_busy && !i_start && r_idx == aesctr_pkg::RK_AW'(aesctr_pkg::NUM_ROUNDS), !r_busy)
endmodule

// File: src/aesctr_cipher.sv
// Round sequencer: one AES round per cycle (the last one holds while the output register is full) with the round
// key read from RAM, keystream XOR, byte masking and the output register. Depends on aesctr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module aesctr_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aesctr_pkg::t_ciph_req         i_req,
    output aesctr_pkg::t_ciph_stat        o_stat,
    output logic [aesctr_pkg::RK_AW-1:0]  o_rk_addr,
    input  logic [127:0]                  i_rk_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [132:0]                  o_payload
);
    aesctr_pkg::t_ciph_state       r_state;
    aesctr_pkg::t_ciph_state       n_state;
    logic [aesctr_pkg::RK_AW-1:0]  r_round;
    logic [aesctr_pkg::RK_AW-1:0]  n_round;
    logic [127:0]                  r_blk;
    logic [127:0]                  n_blk;
    logic [127:0]                  r_data;
    logic [4:0]                    r_nbytes;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [132:0]                  r_out;
    logic                          last_rnd;
    logic                          out_free;
    logic                          finish;
    logic [127:0]                  rnd_out;
    logic [127:0]                  masked;

    assign last_rnd = (r_round == aesctr_pkg::RK_AW'(aesctr_pkg::NUM_ROUNDS));
    assign out_free = !r_out_valid || i_ready;
    assign finish   = (r_state == aesctr_pkg::ST_RUN) && last_rnd && out_free;
    assign rnd_out  = ((r_round == '0) ? r_blk : aesctr_pkg::aes_round(r_blk, last_rnd))
                      ^ i_rk_data;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            masked[127-8*i -: 8] = (5'(i) < r_nbytes)
                ? (rnd_out[127-8*i -: 8] ^ r_data[127-8*i -: 8]) : 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aesctr_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_state = aesctr_pkg::ST_RUN;
                end
            end
            aesctr_pkg::ST_RUN: begin
                if (finish) begin
                    n_state = aesctr_pkg::ST_IDLE;
                end
            end
            default: n_state = aesctr_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_round     = r_round;
        n_blk       = r_blk;
        n_out_valid = r_out_valid && !i_ready;
        o_rk_addr   = '0;
        case (r_state)
            aesctr_pkg::ST_IDLE: begin
                n_round = '0;
                if (i_req.start) begin
                    n_blk = i_req.ctr;
                end
            end
            aesctr_pkg::ST_RUN: begin
                if (!last_rnd) begin
                    n_blk     = rnd_out;
                    n_round   = r_round + 1'b1;
                    o_rk_addr = r_round + 1'b1;
                end else begin
                    // hold the last round key until the output register frees up
                    o_rk_addr = r_round;
                    if (out_free) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aesctr_pkg::ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (r_state == aesctr_pkg::ST_IDLE && i_req.start) begin
            r_data   <= i_req.data;
            r_nbytes <= i_req.nbytes;
        end
        if (finish) begin
            r_out <= {r_nbytes, masked[63:0], masked[127:64]};
        end
    end

    assign o_stat.idle = (r_state == aesctr_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_payload   = r_out;

    `AESCTR_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_req.start, r_state == aesctr_pkg::ST_IDLE)
    `AESCTR_ASSERT_IMP(a_round_range, i_clk, i_rst_n, 1'b1, r_round <= aesctr_pkg::RK_AW'(aesctr_pkg::NUM_ROUNDS))
    `AESCTR_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_state == aesctr_pkg::ST_RUN && last_rnd && !out_free, r_state == aesctr_pkg::ST_RUN && last_rnd)
endmodule

// File: src/aes128_ctr_crypt.sv
// AES-128 CTR: each input transaction is accepted in an idle cycle, then the rounds
// run with the round keys read from the round key RAM, one per round; no new item is
// accepted until the result has gone to the output register. After reset and after
// each key write the key schedule fills the RAM while no item is accepted.
// Synchronous active-low reset: all-zero key and IV, counter width four.
module aes128_ctr_crypt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [63:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [63:0] data_high, [127:64] data_low, [132:128] valid_bytes, [135:133] zero
    input  logic [135:0]  s_axis_tdata,
    // [0] first_block
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [63:0] out_high, [127:64] out_low, [132:128] out_valid_bytes, [135:133] zero
    output logic [135:0]  m_axis_tdata
);
    logic [63:0]                   r_key_high;
    logic [63:0]                   r_key_low;
    logic [63:0]                   r_iv_high;
    logic [63:0]                   r_iv_low;
    logic [4:0]                    r_ctr_w;
    logic [127:0]                  r_ctr;
    logic                          key_wr;
    logic [127:0]                  new_key;
    logic                          accept;
    logic [127:0]                  ctr_use;
    logic                          exp_busy;
    aesctr_pkg::t_rk_wr            rk_wr;
    aesctr_pkg::t_ciph_req         req;
    aesctr_pkg::t_ciph_stat        stat;
    logic [aesctr_pkg::RK_AW-1:0]  rk_addr;
    logic [127:0]                  rk_data;
    logic [132:0]                  payload;

    assign key_wr = i_cfg_we && (i_cfg_addr == aesctr_pkg::REG_KEY_HIGH
                              || i_cfg_addr == aesctr_pkg::REG_KEY_LOW);
    assign new_key = {(i_cfg_addr == aesctr_pkg::REG_KEY_HIGH) ? i_cfg_wdata : r_key_high,
                      (i_cfg_addr == aesctr_pkg::REG_KEY_LOW)  ? i_cfg_wdata : r_key_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
            r_ctr_w    <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                aesctr_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                aesctr_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                aesctr_pkg::REG_IV_HIGH:  r_iv_high  <= i_cfg_wdata;
                aesctr_pkg::REG_IV_LOW:   r_iv_low   <= i_cfg_wdata;
                aesctr_pkg::REG_CTR_W:    r_ctr_w    <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = stat.idle && !exp_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctr_use       = s_axis_tuser ? {r_iv_high, r_iv_low} : r_ctr;

    // advance the counter as the block enters the rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (accept) begin
            r_ctr <= aesctr_pkg::ctr_inc(ctr_use, r_ctr_w);
        end
    end

    assign req.start  = accept;
    assign req.ctr    = ctr_use;
    assign req.data   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign req.nbytes = s_axis_tdata[132:128];

    aesctr_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_wr),
        .i_key   (new_key),
        .o_wr    (rk_wr),
        .o_busy  (exp_busy)
    );

    aesctr_ram #(
        .WIDTH (128),
        .DEPTH (aesctr_pkg::RK_DEPTH)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (rk_wr.we),
        .i_waddr (rk_wr.addr),
        .i_wdata (rk_wr.data),
        .i_raddr (rk_addr),
        .o_rdata (rk_data)
    );

    aesctr_cipher u_cipher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_stat    (stat),
        .o_rk_addr (rk_addr),
        .i_rk_data (rk_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_payload (payload)
    );

    assign m_axis_tdata = {3'b000, payload};
endmodule
